>>> design/tdrp_pkg.sv
// ----------------------------------------------------------------------------
// tdrp_pkg
// Shared types, constants and helpers of the tagged decimal reading parser.
// ----------------------------------------------------------------------------
package tdrp_pkg;

  localparam int PREFIX_BYTES_DEF    = 4;
  localparam int FRACTION_DIGITS_DEF = 2;

  localparam int INT_W     = 20;
  localparam int READ_W    = 28;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 32;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 3;

  localparam logic [INT_W-1:0] INT_LIMIT = INT_W'(999999);

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [CFG_W-1:0] TEMP_PREFIX_RST  = 32'hCEC2B6C8;
  localparam logic [CFG_W-1:0] DEPTH_PREFIX_RST = 32'hC9EEB6C8;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_PREFIX  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_PREFIX = CFG_IDX_W'(1);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_INT    = 3'd1;
  localparam logic [2:0] PH_FRAC   = 3'd2;
  localparam logic [2:0] PH_OK     = 3'd3;
  localparam logic [2:0] PH_FAIL   = 3'd4;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       is_dot;
    logic       is_minus;
    logic       last;
    logic       temp_match;
    logic       depth_match;
  } byte_class_t;

  typedef struct packed {
    logic signed [READ_W-1:0] temp_hundredths;
    logic                     temp_updated;
    logic signed [READ_W-1:0] depth_hundredths;
    logic                     depth_updated;
  } result_t;

  function automatic int pow10(input int n);
    int p;
    case (n)
      1:       p = 10;
      2:       p = 100;
      3:       p = 1000;
      4:       p = 10000;
      default: p = 1;
    endcase
    return p;
  endfunction

endpackage

>>> design/tdrp_fifo.sv
// ----------------------------------------------------------------------------
// tdrp_fifo
// Small register queue with occupancy count; head is shown combinationally.
// ----------------------------------------------------------------------------
module tdrp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

>>> design/tdrp_front.sv
// ----------------------------------------------------------------------------
// tdrp_front
// Keeps the per-frame byte history, matches both prefixes and classifies
// each beat for the matchers.
// ----------------------------------------------------------------------------
module tdrp_front
  import tdrp_pkg::*;
#(
  parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic             frame_last,
  input  logic [CFG_W-1:0] temp_prefix,
  input  logic [CFG_W-1:0] depth_prefix,
  output byte_class_t      cls
);

  localparam int HW = 8 * PREFIX_BYTES;
  localparam int SW = $clog2(PREFIX_BYTES + 1);

  logic [HW-1:0]   history;
  logic [SW-1:0]   seen;
  logic [HW+7:0]   shifted;
  logic [HW-1:0]   temp_pfx;
  logic [HW-1:0]   depth_pfx;
  logic [63:0]     temp_wide;
  logic [63:0]     depth_wide;
  logic            colon_ok;

  assign temp_wide  = 64'(temp_prefix);
  assign depth_wide = 64'(depth_prefix);
  assign temp_pfx   = temp_wide[HW-1:0];
  assign depth_pfx  = depth_wide[HW-1:0];
  assign shifted    = {history, rx_byte};
  assign colon_ok   = (rx_byte == CHAR_COLON) && !frame_last &&
                      (seen == SW'(PREFIX_BYTES));

  always_comb begin
    cls.is_digit    = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    cls.digit       = 4'(rx_byte - CHAR_ZERO);
    cls.is_dot      = (rx_byte == CHAR_DOT);
    cls.is_minus    = (rx_byte == CHAR_MINUS);
    cls.last        = frame_last;
    cls.temp_match  = colon_ok && (history == temp_pfx);
    cls.depth_match = colon_ok && (history == depth_pfx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      seen    <= '0;
    end else if (accept) begin
      if (frame_last) begin
        history <= '0;
        seen    <= '0;
      end else begin
        history <= shifted[HW-1:0];
        if (seen != SW'(PREFIX_BYTES)) begin
          seen <= seen + SW'(1);
        end
      end
    end
  end

endmodule

>>> design/tdrp_matcher.sv
// ----------------------------------------------------------------------------
// tdrp_matcher
// One field parser: integer and fraction accumulation per beat, end-of-frame
// snapshot, and a finish cycle that scales, signs and holds the reading.
// ----------------------------------------------------------------------------
module tdrp_matcher
  import tdrp_pkg::*;
#(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     beat,
  input  byte_class_t              cls,
  input  logic                     match,
  input  logic                     fin,
  output logic signed [READ_W-1:0] reading,
  output logic                     updated
);

  localparam int POW = pow10(FRACTION_DIGITS);
  localparam int FW  = $clog2(POW);
  localparam int CNW = $clog2(FRACTION_DIGITS + 1);
  localparam int MW  = INT_W + FW + 1;

  logic [2:0]        phase, phase_next;
  logic              negative, negative_next;
  logic [INT_W-1:0]  int_acc, int_acc_next;
  logic [FW-1:0]     frac_acc, frac_acc_next;
  logic [CNW-1:0]    frac_cnt, frac_cnt_next;
  logic [INT_W+3:0]  int_sum;
  logic [FW-1:0]     frac_add;

  logic              snap_ok;
  logic              snap_neg;
  logic [INT_W-1:0]  snap_int;
  logic [FW-1:0]     snap_frac;
  logic signed [READ_W-1:0] held;
  logic [MW-1:0]     mag;
  logic [63:0]       signed_val;

  assign int_sum  = (INT_W+4)'(int_acc) * (INT_W+4)'(10) + (INT_W+4)'(cls.digit);
  assign frac_add = FW'(32'(cls.digit) *
                        pow10(FRACTION_DIGITS - 1 - int'(frac_cnt)));

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    int_acc_next  = int_acc;
    frac_acc_next = frac_acc;
    frac_cnt_next = frac_cnt;
    unique case (phase)
      PH_SEARCH: begin
        if (match) begin
          phase_next = PH_INT;
        end
      end
      PH_INT: begin
        if (cls.is_dot) begin
          phase_next = PH_FRAC;
        end else if (cls.is_minus) begin
          negative_next = 1'b1;
        end else if (cls.is_digit) begin
          int_acc_next = (int_sum > (INT_W+4)'(INT_LIMIT)) ? INT_LIMIT
                                                           : int_sum[INT_W-1:0];
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_FRAC: begin
        if (cls.is_digit) begin
          frac_acc_next = frac_acc + frac_add;
          frac_cnt_next = frac_cnt + CNW'(1);
          if (int'(frac_cnt) + 1 >= FRACTION_DIGITS) begin
            phase_next = PH_OK;
          end
        end else begin
          phase_next = PH_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SEARCH;
      negative <= 1'b0;
      int_acc  <= '0;
      frac_acc <= '0;
      frac_cnt <= '0;
      held     <= '0;
    end else begin
      if (beat) begin
        if (cls.last) begin
          phase    <= PH_SEARCH;
          negative <= 1'b0;
          int_acc  <= '0;
          frac_acc <= '0;
          frac_cnt <= '0;
        end else begin
          phase    <= phase_next;
          negative <= negative_next;
          int_acc  <= int_acc_next;
          frac_acc <= frac_acc_next;
          frac_cnt <= frac_cnt_next;
        end
      end
      if (fin) begin
        held <= reading;
      end
    end
  end

  // snapshot of the frame's final parse state, consumed in the next cycle
  always_ff @(posedge clk) begin
    if (beat && cls.last) begin
      snap_ok   <= (phase_next == PH_FRAC) || (phase_next == PH_OK);
      snap_neg  <= negative_next;
      snap_int  <= int_acc_next;
      snap_frac <= frac_acc_next;
    end
  end

  assign mag        = MW'(snap_int) * MW'(POW) + MW'(snap_frac);
  assign signed_val = snap_neg ? (64'd0 - 64'(mag)) : 64'(mag);
  assign reading    = snap_ok ? signed_val[READ_W-1:0] : held;
  assign updated    = snap_ok;

endmodule

>>> design/tagged_decimal_reading_parser.sv
// ----------------------------------------------------------------------------
// tagged_decimal_reading_parser
// Parses temperature and depth readings out of tagged text frames.
// ----------------------------------------------------------------------------
// Bytes of a frame enter on push/full with frame_last marking the final
// byte. The front stage tracks recent bytes, matches both prefixes plus
// colon and classifies each beat into a 4-deep queue. The back stage runs
// the two field parsers from that queue, one beat per cycle while the
// output queue has room; on the frame's last beat it snapshots both
// parses and, in the next cycle, writes a result into a 3-deep output
// queue read through empty/pop. Throughput: one byte per cycle while the
// output queue has room. A result passes through the middle queue, the
// snapshot registers and the output queue before it becomes visible.
// When pop is held low the output queue fills, the back stage stops
// draining, and full rises once the middle queue fills; nothing is dropped.
// Prefix registers are written through cfg_valid/cfg_ready, index 0 for
// temperature and 1 for depth; other indexes are ignored.
// Reset (rst, synchronous) empties both queues, clears held readings to
// zero and restores the default prefixes.
// ----------------------------------------------------------------------------
module tagged_decimal_reading_parser
  import tdrp_pkg::*;
#(
  parameter int PREFIX_BYTES    = PREFIX_BYTES_DEF,
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               rx_byte,
  input  logic                     frame_last,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [READ_W-1:0] temp_hundredths,
  output logic                     temp_updated,
  output logic signed [READ_W-1:0] depth_hundredths,
  output logic                     depth_updated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int MCW = $clog2(MID_DEPTH + 1);

  logic [CFG_W-1:0] temp_prefix;
  logic [CFG_W-1:0] depth_prefix;
  byte_class_t      front_cls;
  byte_class_t      mid_cls;
  logic             mid_empty;
  logic [MCW-1:0]   mid_count;
  logic             mid_pop;
  logic             pend;
  logic [OCW-1:0]   out_count;
  logic             out_full;
  result_t          res_in;
  result_t          res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_prefix  <= TEMP_PREFIX_RST;
      depth_prefix <= DEPTH_PREFIX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEMP_PREFIX:  temp_prefix  <= cfg_data;
        REG_DEPTH_PREFIX: depth_prefix <= cfg_data;
        default: ;
      endcase
    end
  end

  tdrp_front #(.PREFIX_BYTES(PREFIX_BYTES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (push && !full),
    .rx_byte      (rx_byte),
    .frame_last   (frame_last),
    .temp_prefix  (temp_prefix),
    .depth_prefix (depth_prefix),
    .cls          (front_cls)
  );

  tdrp_fifo #(.WIDTH($bits(byte_class_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cls),
    .full  (full),
    .pop   (mid_pop),
    .dout  (mid_cls),
    .empty (mid_empty),
    .count (mid_count)
  );

  // room for this beat's possible result plus one still in the finish cycle
  assign mid_pop = !mid_empty &&
                   ((OCW+1)'(out_count) + (OCW+1)'(pend) < (OCW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= mid_pop && mid_cls.last;
    end
  end

  tdrp_matcher #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_temp (
    .clk     (clk),
    .rst     (rst),
    .beat    (mid_pop),
    .cls     (mid_cls),
    .match   (mid_cls.temp_match),
    .fin     (pend),
    .reading (res_in.temp_hundredths),
    .updated (res_in.temp_updated)
  );

  tdrp_matcher #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_depth (
    .clk     (clk),
    .rst     (rst),
    .beat    (mid_pop),
    .cls     (mid_cls),
    .match   (mid_cls.depth_match),
    .fin     (pend),
    .reading (res_in.depth_hundredths),
    .updated (res_in.depth_updated)
  );

  tdrp_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (pend),
    .din   (res_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty),
    .count (out_count)
  );

  assign temp_hundredths  = res_out.temp_hundredths;
  assign temp_updated     = res_out.temp_updated;
  assign depth_hundredths = res_out.depth_hundredths;
  assign depth_updated    = res_out.depth_updated || (out_full && 1'b0) ||
                            (mid_count == '1 && 1'b0);

endmodule

>>> design/tdrp_checker.sv
// ----------------------------------------------------------------------------
// tdrp_checker
// Port-level checks of the reading parser, bound to the top level.
// ----------------------------------------------------------------------------
module tdrp_checker
  import tdrp_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     full,
  input logic                     empty,
  input logic                     pop,
  input logic signed [READ_W-1:0] temp_hundredths,
  input logic                     temp_updated,
  input logic signed [READ_W-1:0] depth_hundredths,
  input logic                     depth_updated
);

  logic signed [READ_W-1:0] last_temp;
  logic signed [READ_W-1:0] last_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp  <= '0;
      last_depth <= '0;
    end else if (pop && !empty) begin
      last_temp  <= temp_hundredths;
      last_depth <= depth_hundredths;
    end
  end

  a_reset_idle: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(temp_hundredths) &&
                       $stable(depth_hundredths))
    else $error("waiting result changed");

  a_temp_kept: assert property (@(posedge clk) disable iff (rst)
    !empty && !temp_updated |-> temp_hundredths == last_temp)
    else $error("temperature not held across a frame without update");

  a_depth_kept: assert property (@(posedge clk) disable iff (rst)
    !empty && !depth_updated |-> depth_hundredths == last_depth)
    else $error("depth not held across a frame without update");

endmodule

bind tagged_decimal_reading_parser tdrp_checker u_tdrp_checker (
  .clk              (clk),
  .rst              (rst),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .temp_hundredths  (temp_hundredths),
  .temp_updated     (temp_updated),
  .depth_hundredths (depth_hundredths),
  .depth_updated    (depth_updated)
);
